// ----- src/bpcw_pkg.sv -----
// shared types and constants for the bsp point contents walker
package bpcw_pkg;

  // operand widths of the shared multiply-accumulate unit
  localparam int unsigned NormW = 16;  // Q1.14 normal component
  localparam int unsigned PosW  = 32;  // Q19.12 coordinate or distance
  localparam int unsigned ProdW = NormW + PosW;
  // three products plus the shifted distance stay well inside 50 bits
  localparam int unsigned AccW  = 50;
  // moves a Q.12 distance onto the Q.26 scale of the products
  localparam int unsigned DistShift = 14;

  // command carried with each input item
  typedef enum logic [1:0] {
    CMD_WR_PLANE = 2'd0,
    CMD_WR_NODE  = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_QUERY_N  = 2'd3
  } cmd_e;

  // control of the multiply-accumulate unit for one cycle
  typedef struct packed {
    logic mul;    // register a new product
    logic load;   // start the sum from the negated, scaled distance
    logic accum;  // add the registered product into the sum
  } mac_ctrl_t;

endpackage

// ----- src/bpcw_ram.sv -----
// single-port-write, single-port-read table with registered read data
module bpcw_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 38
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bpcw_mac.sv -----
// shared multiply-accumulate unit for the plane distance n.p - d
module bpcw_mac (
  input  logic                                clk_i,
  input  bpcw_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [bpcw_pkg::NormW-1:0]   a_i,
  input  logic signed [bpcw_pkg::PosW-1:0]    b_i,
  input  logic signed [bpcw_pkg::PosW-1:0]    dist_i,
  output logic signed [bpcw_pkg::AccW-1:0]    sum_o
);

  logic signed [bpcw_pkg::ProdW-1:0] prod_q;
  logic signed [bpcw_pkg::AccW-1:0]  acc_q;
  logic signed [bpcw_pkg::AccW-1:0]  dist_scaled;

  assign dist_scaled = bpcw_pkg::AccW'(dist_i) <<< bpcw_pkg::DistShift;
  // running sum including the product still in its register
  assign sum_o = acc_q + bpcw_pkg::AccW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.load) begin
      acc_q <= -dist_scaled;
    end else if (ctrl_i.accum) begin
      acc_q <= sum_o;
    end
  end

endmodule

// ----- src/bsp_point_contents_walk.sv -----
// top level of the bsp point contents walker: tables, walk sequencer, output register
// writes: a plane or node write is taken and gives no item
// a query whose start node is a leaf skips the walk and goes to S_OUT, then the output register
// a walk steps through each tree level as node read, plane read, three multiplies
// through the one shared multiplier and side decision, then S_OUT to the output register
// throughput: one query at a time, input ready again once the result is registered
// reset: asynchronous, active low; clears the sequencer and output valid, tables are undefined
module bsp_point_contents_walk #(
  parameter int unsigned NODE_COUNT  = 4096,
  parameter int unsigned PLANE_COUNT = 4096,
  parameter int unsigned MAX_STEPS   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // entry_index, plane_ref, child_front, child_back, normal_x, normal_y, normal_z,
  // plane_dist, pos_x, pos_y, pos_z, zero fill
  input  logic [231:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // contents, hit_normal_x, hit_normal_y, hit_normal_z, zero fill
  output logic [55:0]  m_axis_tdata_o,
  // step_overrun
  output logic [0:0]   m_axis_tuser_o
);

  localparam int unsigned NodeAw = $clog2(NODE_COUNT);
  localparam int unsigned PlaneAw = $clog2(PLANE_COUNT);
  localparam int unsigned StepW = $clog2(MAX_STEPS + 1);
  localparam int unsigned IdxW = 13;
  localparam int unsigned NormW = bpcw_pkg::NormW;
  localparam int unsigned PosW = bpcw_pkg::PosW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NODE  = 8'b0000_0010,
    S_PLANE = 8'b0000_0100,
    S_MX    = 8'b0000_1000,
    S_MY    = 8'b0001_0000,
    S_MZ    = 8'b0010_0000,
    S_DEC   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // node entry, plane index in the low bits
  typedef struct packed {
    logic signed [IdxW-1:0] back;
    logic signed [IdxW-1:0] front;
    logic [11:0]            plane;
  } node_t;

  // plane entry, normal x in the low bits
  typedef struct packed {
    logic signed [PosW-1:0]  offset;
    logic signed [NormW-1:0] nz;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nx;
  } plane_t;

  // negation that saturates the single value without a positive twin
  function automatic logic signed [NormW-1:0] neg_sat(input logic signed [NormW-1:0] v);
    logic signed [NormW-1:0] r;
    r = -v;
    if (v == {1'b1, {(NormW-1){1'b0}}}) begin
      r = {1'b0, {(NormW-1){1'b1}}};
    end
    return r;
  endfunction

  // unpack the input item
  bpcw_pkg::cmd_e          in_cmd;
  logic signed [IdxW-1:0]  in_idx;
  logic [11:0]             in_plane_ref;
  logic signed [IdxW-1:0]  in_front;
  logic signed [IdxW-1:0]  in_back;
  logic signed [NormW-1:0] in_nx;
  logic signed [NormW-1:0] in_ny;
  logic signed [NormW-1:0] in_nz;
  logic signed [PosW-1:0]  in_dist;
  logic signed [PosW-1:0]  in_px;
  logic signed [PosW-1:0]  in_py;
  logic signed [PosW-1:0]  in_pz;

  assign in_cmd       = bpcw_pkg::cmd_e'(s_axis_tuser_i);
  assign in_idx       = $signed(s_axis_tdata_i[12:0]);
  assign in_plane_ref = s_axis_tdata_i[24:13];
  assign in_front     = $signed(s_axis_tdata_i[37:25]);
  assign in_back      = $signed(s_axis_tdata_i[50:38]);
  assign in_nx        = $signed(s_axis_tdata_i[66:51]);
  assign in_ny        = $signed(s_axis_tdata_i[82:67]);
  assign in_nz        = $signed(s_axis_tdata_i[98:83]);
  assign in_dist      = $signed(s_axis_tdata_i[130:99]);
  assign in_px        = $signed(s_axis_tdata_i[162:131]);
  assign in_py        = $signed(s_axis_tdata_i[194:163]);
  assign in_pz        = $signed(s_axis_tdata_i[226:195]);

  state_e state_q, state_d;

  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // query context
  logic signed [PosW-1:0] px_q, py_q, pz_q;
  logic                   strict_q;
  logic [11:0]            cur_q, cur_d;
  logic [StepW-1:0]       steps_q, steps_d;
  logic                   node_oob_q, plane_oob_q;

  // staged result, moved to the output register in S_OUT
  logic [4:0]              res_contents_q, res_contents_d;
  logic signed [NormW-1:0] res_nx_q, res_nx_d;
  logic signed [NormW-1:0] res_ny_q, res_ny_d;
  logic signed [NormW-1:0] res_nz_q, res_nz_d;
  logic                    res_over_q, res_over_d;

  logic        m_tvalid_q;
  logic [55:0] m_tdata_q;
  logic [0:0]  m_tuser_q;

  // writes land only for indexes inside the table
  logic idx_ok_node, idx_ok_plane;
  assign idx_ok_node  = !in_idx[IdxW-1] && ({20'd0, in_idx[11:0]} < 32'(NODE_COUNT));
  assign idx_ok_plane = !in_idx[IdxW-1] && ({20'd0, in_idx[11:0]} < 32'(PLANE_COUNT));

  // node table
  logic [$bits(node_t)-1:0] node_rdata;
  node_t                    node_wr, node_eff;
  assign node_wr = '{back: in_back, front: in_front, plane: in_plane_ref};

  bpcw_ram #(
    .Depth (NODE_COUNT),
    .Width ($bits(node_t))
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_cmd == bpcw_pkg::CMD_WR_NODE) && idx_ok_node),
    .waddr_i (NodeAw'(in_idx[11:0])),
    .wdata_i (node_wr),
    .re_i    (state_q == S_NODE),
    .raddr_i (NodeAw'(cur_q)),
    .rdata_o (node_rdata)
  );

  // an out of range node reads as plane 0 with both children 0
  assign node_eff = node_oob_q ? '0 : node_t'(node_rdata);

  // plane table, normal and distance side by side
  logic [$bits(plane_t)-1:0] plane_rdata;
  plane_t                    plane_wr, plane_eff;
  assign plane_wr = '{offset: in_dist, nz: in_nz, ny: in_ny, nx: in_nx};

  bpcw_ram #(
    .Depth (PLANE_COUNT),
    .Width ($bits(plane_t))
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_cmd == bpcw_pkg::CMD_WR_PLANE) && idx_ok_plane),
    .waddr_i (PlaneAw'(in_idx[11:0])),
    .wdata_i (plane_wr),
    .re_i    (state_q == S_PLANE),
    .raddr_i (PlaneAw'(node_eff.plane)),
    .rdata_o (plane_rdata)
  );

  assign plane_eff = plane_oob_q ? '0 : plane_t'(plane_rdata);

  // shared multiply-accumulate: one component product per cycle
  bpcw_pkg::mac_ctrl_t     mac_ctrl;
  logic signed [NormW-1:0] mac_a;
  logic signed [PosW-1:0]  mac_b;
  logic signed [bpcw_pkg::AccW-1:0] mac_sum;

  always_comb begin
    mac_ctrl.mul   = (state_q == S_MX) || (state_q == S_MY) || (state_q == S_MZ);
    mac_ctrl.load  = (state_q == S_MX);
    mac_ctrl.accum = (state_q == S_MY) || (state_q == S_MZ);
    unique case (state_q)
      S_MX: begin
        mac_a = plane_eff.nx;
        mac_b = px_q;
      end
      S_MY: begin
        mac_a = plane_eff.ny;
        mac_b = py_q;
      end
      S_MZ: begin
        mac_a = plane_eff.nz;
        mac_b = pz_q;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  bpcw_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .dist_i (plane_eff.offset),
    .sum_o  (mac_sum)
  );

  // side decision: contents query keeps zero on the front, normal query does not
  logic                   dec_front;
  logic signed [IdxW-1:0] dec_next;
  logic                   dec_leaf;
  logic                   dec_over;
  assign dec_front = strict_q ? (!mac_sum[bpcw_pkg::AccW-1] && (mac_sum != '0))
                              : !mac_sum[bpcw_pkg::AccW-1];
  assign dec_next  = dec_front ? node_eff.front : node_eff.back;
  assign dec_leaf  = dec_next[IdxW-1];
  assign dec_over  = !dec_leaf && (steps_q == StepW'(MAX_STEPS - 1));

  logic out_free;
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  // walk sequencer
  always_comb begin
    state_d        = state_q;
    cur_d          = cur_q;
    steps_d        = steps_q;
    res_contents_d = res_contents_q;
    res_nx_d       = res_nx_q;
    res_ny_d       = res_ny_q;
    res_nz_d       = res_nz_q;
    res_over_d     = res_over_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && ((in_cmd == bpcw_pkg::CMD_QUERY) ||
                       (in_cmd == bpcw_pkg::CMD_QUERY_N))) begin
          steps_d = '0;
          cur_d   = in_idx[11:0];
          if (in_idx[IdxW-1]) begin
            // start node already a leaf: answer straight away
            res_contents_d = in_idx[4:0];
            res_nx_d       = '0;
            res_ny_d       = '0;
            res_nz_d       = '0;
            res_over_d     = 1'b0;
            state_d        = S_OUT;
          end else begin
            state_d = S_NODE;
          end
        end
      end
      S_NODE:  state_d = S_PLANE;
      S_PLANE: state_d = S_MX;
      S_MX:    state_d = S_MY;
      S_MY:    state_d = S_MZ;
      S_MZ:    state_d = S_DEC;
      S_DEC: begin
        if (dec_leaf) begin
          res_contents_d = dec_next[4:0];
          res_over_d     = 1'b0;
          if (!strict_q) begin
            res_nx_d = '0;
            res_ny_d = '0;
            res_nz_d = '0;
          end else if (dec_front) begin
            res_nx_d = plane_eff.nx;
            res_ny_d = plane_eff.ny;
            res_nz_d = plane_eff.nz;
          end else begin
            res_nx_d = neg_sat(plane_eff.nx);
            res_ny_d = neg_sat(plane_eff.ny);
            res_nz_d = neg_sat(plane_eff.nz);
          end
          state_d = S_OUT;
        end else if (dec_over) begin
          // step limit hit: flag and zero everything else
          res_contents_d = '0;
          res_nx_d       = '0;
          res_ny_d       = '0;
          res_nz_d       = '0;
          res_over_d     = 1'b1;
          state_d        = S_OUT;
        end else begin
          cur_d   = dec_next[11:0];
          steps_d = steps_q + StepW'(1);
          state_d = S_NODE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_OUT) && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q          <= cur_d;
    steps_q        <= steps_d;
    res_contents_q <= res_contents_d;
    res_nx_q       <= res_nx_d;
    res_ny_q       <= res_ny_d;
    res_nz_q       <= res_nz_d;
    res_over_q     <= res_over_d;
    if (in_acc) begin
      px_q     <= in_px;
      py_q     <= in_py;
      pz_q     <= in_pz;
      strict_q <= (in_cmd == bpcw_pkg::CMD_QUERY_N);
    end
    if (state_q == S_NODE) begin
      node_oob_q <= ({20'd0, cur_q} >= 32'(NODE_COUNT));
    end
    if (state_q == S_PLANE) begin
      plane_oob_q <= ({20'd0, node_eff.plane} >= 32'(PLANE_COUNT));
    end
    if ((state_q == S_OUT) && out_free) begin
      m_tdata_q <= {3'b000, res_nz_q, res_ny_q, res_nx_q, res_contents_q};
      m_tuser_q <= res_over_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  // sequencer keeps exactly one state bit set
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost its one-hot code");

  // a leaf start node skips the walk
  a_leaf_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_idx[IdxW-1] && ((in_cmd == bpcw_pkg::CMD_QUERY) ||
                                  (in_cmd == bpcw_pkg::CMD_QUERY_N)))
    |=> (state_q == S_OUT))
    else $error("leaf start node did not go to output");

  // step counter never passes the limit during a walk
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> (steps_q <= StepW'(MAX_STEPS - 1)))
    else $error("walk step counter beyond limit");

  // overrun result carries only the flag
  a_overrun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DEC) && dec_over) |=>
    (res_over_q && (res_contents_q == '0) && (res_nx_q == '0) && (res_ny_q == '0)
     && (res_nz_q == '0)))
    else $error("overrun result not cleared");

  // contents query never reports a normal once its walk ends
  a_contents_no_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DEC) && !strict_q && (dec_leaf || dec_over)) |=>
    ((res_nx_q == '0) && (res_ny_q == '0) && (res_nz_q == '0)))
    else $error("contents query produced a normal");

endmodule
